// ----- hdl/cee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_pkg
// Types, field constants and the GF(2^16) multiply shared by the encoder.
// ----------------------------------------------------------------------------
package cee_pkg;

	localparam int SymW     = 16;
	localparam int IdxW     = 8;
	localparam int RowW     = 4;
	localparam int RowSlots = 16;
	localparam int NInfoW   = 9;
	localparam int NRedW    = 5;
	localparam int CfgW     = 9;

	localparam logic [SymW-1:0] GfLowTaps = 16'h002B;

	typedef logic [SymW-1:0] sym_t;

	typedef enum logic {
		REG_NUM_INFO       = 1'b0,
		REG_NUM_REDUNDANCY = 1'b1
	} cfg_reg_t;

	// Shift-and-add multiply in GF(2^16), most significant bit of b first.
	function automatic sym_t gf_mul(input sym_t a, input sym_t b);
		sym_t acc;
		acc = '0;
		for (int bit_i = SymW - 1; bit_i >= 0; bit_i--) begin
			acc = acc[SymW-1] ? ({acc[SymW-2:0], 1'b0} ^ GfLowTaps) : {acc[SymW-2:0], 1'b0};
			if (b[bit_i]) begin
				acc = acc ^ a;
			end
		end
		return acc;
	endfunction

endpackage

// ----- hdl/cee_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_info_if / cee_parity_if
// Valid/ready channels for info symbols and parity symbols.
// ----------------------------------------------------------------------------
interface cee_info_if;
	logic        valid;
	logic        ready;
	logic [15:0] info_symbol;
	logic [7:0]  info_index;
	logic        word_last;
	modport source (output valid, info_symbol, info_index, word_last, input ready);
	modport sink   (input valid, info_symbol, info_index, word_last, output ready);
endinterface

interface cee_parity_if;
	logic        valid;
	logic        ready;
	logic [15:0] parity_symbol;
	logic [3:0]  row_index;
	logic        row_last;
	logic        packet_end;
	modport source (output valid, parity_symbol, row_index, row_last, packet_end, input ready);
	modport sink   (input valid, parity_symbol, row_index, row_last, packet_end, output ready);
endinterface

// ----- hdl/cauchy_erasure_encoder.sv -----
`timescale 1ns / 1ps
// An info symbol is worked one at a time: the XOR row takes the memory
// read-modify-write alone, every further row first an inverse by repeated
// squaring and then the read-modify-write, over all the configured rows.
// A closing symbol adds a sweep that reads out and clears all sixteen
// accumulators one entry at a time; it waits while the parity sink stalls.
// Reset clears the valid bits, the column flag and the control registers.
// ----------------------------------------------------------------------------
// cauchy_erasure_encoder
// Cauchy Reed-Solomon erasure encoder over GF(2^16), accumulators in a RAM.
// ----------------------------------------------------------------------------
module cauchy_erasure_encoder #(
	parameter int MAX_INFO       = 256,
	parameter int MAX_REDUNDANCY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cee_info_if.sink              info,
	cee_parity_if.source          parity,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [cee_pkg::CfgW-1:0] cfg_data
);
	import cee_pkg::*;

	// The info cap is clipped to the register width, the redundancy cap to the
	// sixteen row slots.
	localparam int InfoCap = (MAX_INFO > 511) ? 511 : MAX_INFO;
	localparam int RedCap  = (MAX_REDUNDANCY > RowSlots) ? RowSlots : MAX_REDUNDANCY;

	typedef enum logic [2:0] {
		S_IDLE, S_INV, S_RD, S_WR, S_ORD, S_OUT
	} state_t;

	state_t              state_q;
	logic [NInfoW-1:0]   num_info_q;
	logic [NRedW-1:0]    num_red_q;
	logic [NInfoW-1:0]   n_eff;
	logic [NRedW-1:0]    rows_eff;

	sym_t                sym_q;
	logic [IdxW-1:0]     idx_q;
	logic [NRedW-1:0]    rows_q;
	logic [NRedW-1:0]    row_q;
	logic [NInfoW-1:0]   n_q;
	logic                close_q;
	logic                final_q;
	sym_t                sq_q;
	sym_t                inv_q;
	logic [RowW:0]       cnt_q;

	// Accumulator RAM with one valid bit per entry: an entry never written since
	// reset reads as zero.
	sym_t                acc_mem [RowSlots];
	logic [RowSlots-1:0] vld_q;
	logic [RowW-1:0]     rd_addr;
	sym_t                rd_data_q;
	logic                rd_vld_q;
	sym_t                acc_rd;
	logic                mem_we;
	logic [RowW-1:0]     wr_addr;
	sym_t                wr_data;

	logic                take;
	logic                keep;
	logic [NInfoW:0]     a_sum;
	sym_t                a_val;
	logic                out_free;
	logic                send;

	assign n_eff    = (num_info_q > NInfoW'(InfoCap)) ? NInfoW'(InfoCap) : num_info_q;
	assign rows_eff = (num_red_q > NRedW'(RedCap)) ? NRedW'(RedCap) : num_red_q;

	assign info.ready = (state_q == S_IDLE);
	assign take       = info.valid && info.ready;
	assign keep       = {1'b0, info.info_index} < n_eff;
	assign out_free   = !parity.valid || parity.ready;
	assign send       = (state_q == S_OUT) && out_free && (row_q < rows_q);

	// Cauchy element for the row after row_q: with r = row_q + 1 this is
	// (n + r - 1) XOR index, zero-extended.
	assign a_sum = {1'b0, n_q} + {{(NInfoW + 1 - NRedW){1'b0}}, row_q};
	assign a_val = SymW'(a_sum) ^ {{(SymW - IdxW){1'b0}}, idx_q};

	assign acc_rd  = rd_vld_q ? rd_data_q : '0;
	assign rd_addr = row_q[RowW-1:0];
	assign wr_addr = row_q[RowW-1:0];
	assign mem_we  = (state_q == S_WR) || (state_q == S_OUT && out_free);
	assign wr_data = (state_q == S_WR) ? (acc_rd ^ gf_mul(sym_q, inv_q)) : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			acc_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= acc_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_info_q <= NInfoW'(1);
			num_red_q  <= NRedW'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUM_INFO:       num_info_q <= cfg_data[NInfoW-1:0];
				REG_NUM_REDUNDANCY: num_red_q  <= cfg_data[NRedW-1:0];
				default:            ;
			endcase
		end
	end

	// Sequencer: per row, invert the Cauchy element by repeated squaring (the XOR
	// row needs none), then read-modify-write the accumulator. A closing symbol
	// then sweeps the RAM, sending the live rows and clearing every entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= S_IDLE;
			final_q              <= 1'b0;
			close_q              <= 1'b0;
			row_q                <= '0;
			rows_q               <= '0;
			cnt_q                <= '0;
			parity.valid         <= 1'b0;
			parity.parity_symbol <= '0;
			parity.row_index     <= '0;
			parity.row_last      <= 1'b0;
			parity.packet_end    <= 1'b0;
		end else begin
			if (send) begin
				parity.valid <= 1'b1;
			end else if (parity.valid && parity.ready) begin
				parity.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take && keep) begin
						sym_q   <= info.info_symbol;
						idx_q   <= info.info_index;
						n_q     <= n_eff;
						rows_q  <= rows_eff;
						close_q <= ({1'b0, info.info_index} == n_eff - 1'b1);
						row_q   <= '0;
						if (info.word_last) begin
							final_q <= 1'b1;
						end
						if (rows_eff == '0) begin
							state_q <= ({1'b0, info.info_index} == n_eff - 1'b1) ? S_ORD : S_IDLE;
						end else begin
							inv_q   <= SymW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_INV: begin
					sq_q  <= gf_mul(sq_q, sq_q);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != '0) begin
						inv_q <= gf_mul(inv_q, sq_q);
					end
					if (cnt_q == (RowW + 1)'(RowSlots - 1)) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (row_q + 1'b1 < rows_q) begin
						row_q   <= row_q + 1'b1;
						sq_q    <= a_val ^ '0;
						state_q <= S_INV;
					end else begin
						row_q   <= '0;
						state_q <= close_q ? S_ORD : S_IDLE;
					end
					cnt_q <= '0;
					inv_q <= SymW'(1);
				end
				S_ORD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						if (row_q < rows_q) begin
							parity.parity_symbol <= acc_rd;
							parity.row_index     <= row_q[RowW-1:0];
							parity.row_last      <= (row_q + 1'b1 == rows_q);
							parity.packet_end    <= final_q;
						end
						if (row_q == NRedW'(RowSlots - 1)) begin
							row_q   <= '0;
							final_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/cee_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_checker
// Port-level checks on the erasure encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_symbol,
	input logic [3:0]  out_row,
	input logic        out_last
);

	// A stalled parity transfer keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_row))
		else $error("parity payload changed while stalled");

	// Row fifteen is always the final row of a column.
	a_row15: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_row == 4'd15 |-> out_last)
		else $error("row fifteen not marked last");

	// While further rows of a column remain, no info transfer is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("info accepted while parity rows remain");

	// The first row of a column is never the follow-on of an unfinished one.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !(out_valid && out_row == 4'd0))
		else $error("column restarted before its last row");

endmodule

bind cauchy_erasure_encoder cee_checker u_cee_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (info.ready),
	.out_valid  (parity.valid),
	.out_ready  (parity.ready),
	.out_symbol (parity.parity_symbol),
	.out_row    (parity.row_index),
	.out_last   (parity.row_last)
);

// ----- test/cauchy_erasure_encoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cauchy_erasure_encoder_checker
// Watches the info and parity channels and the register port, predicts each
// parity symbol in GF(2^16) and compares it with what the encoder sends.
// ----------------------------------------------------------------------------
module cauchy_erasure_encoder_checker (
	input  logic  clk,
	input  logic  arst_n,
	cee_info_if   info,
	cee_parity_if parity,
	input  logic  cfg_we,
	input  logic  cfg_index,
	input  logic [cee_pkg::CfgW-1:0] cfg_data,
	output int    failures,
	output int    pending,
	output int    symbols_seen,
	output int    parity_seen
);
	import cee_pkg::*;

	typedef struct packed {
		logic [15:0] symbol;
		logic [3:0]  row;
		logic        row_last;
		logic        packet_end;
	} parity_word_t;

	parity_word_t parity_due[$];
	logic [15:0]  row_acc [16];
	logic         column_final;
	logic [8:0]   info_count;
	logic [4:0]   red_count;

	// Multiply, least significant bit of b first.
	function automatic logic [15:0] field_mul(logic [15:0] a, logic [15:0] b);
		logic [15:0] prod;
		prod = '0;
		for (int i = 0; i < 16; i++) begin
			if (b[i]) prod ^= a;
			a = a[15] ? ((a << 1) ^ 16'h002B) : (a << 1);
		end
		return prod;
	endfunction

	// Inverse as a^(2^16-2); zero maps to zero.
	function automatic logic [15:0] field_inv(logic [15:0] a);
		logic [15:0] r;
		r = 16'd1;
		for (int i = 15; i >= 0; i--) begin
			r = field_mul(r, r);
			if (i != 0) r = field_mul(r, a);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n, rows;
		parity_word_t got, want;
		if (!arst_n) begin
			for (int r = 0; r < 16; r++) row_acc[r] = '0;
			column_final = 1'b0;
			info_count = 9'd1;
			red_count = 5'd1;
			parity_due.delete();
			failures = 0;
			pending = 0;
			symbols_seen = 0;
			parity_seen = 0;
		end else begin
			// Parity first, so that the queue reflects results already due.
			if (parity.valid && parity.ready) begin
				parity_seen++;
				got = '{parity.parity_symbol, parity.row_index, parity.row_last,
					parity.packet_end};
				if (parity_due.size() == 0) begin
					failures++;
					$display("%0t: unexpected parity transfer, actual %h", $time, got);
				end else begin
					want = parity_due.pop_front();
					if (got !== want) begin
						failures++;
						$display("%0t: parity mismatch, expected sym %h row %0d last %b end %b, actual sym %h row %0d last %b end %b",
							$time, want.symbol, want.row, want.row_last, want.packet_end,
							got.symbol, got.row, got.row_last, got.packet_end);
					end
				end
			end
			if (info.valid && info.ready) begin
				symbols_seen++;
				n = (info_count > 256) ? 256 : info_count;
				rows = (red_count > 16) ? 16 : red_count;
				if (info.info_index < n) begin
					if (info.word_last) column_final = 1'b1;
					for (int r = 0; r < rows; r++) begin
						if (r == 0)
							row_acc[0] ^= info.info_symbol;
						else
							row_acc[r] ^= field_mul(info.info_symbol,
								field_inv(16'((n + r - 1) ^ info.info_index)));
					end
					if (info.info_index == n - 1) begin
						for (int r = 0; r < rows; r++)
							parity_due.push_back('{row_acc[r], 4'(r), r == rows - 1,
								column_final});
						for (int r = 0; r < 16; r++) row_acc[r] = '0;
						column_final = 1'b0;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_NUM_INFO)
					info_count = cfg_data;
				else
					red_count = cfg_data[4:0];
			end
			pending = parity_due.size();
		end
	end

endmodule

// ----- test/cauchy_erasure_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cauchy_erasure_encoder_tb
// Drives info symbols in whole columns, with stray and reordered transfers,
// across several register settings, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module cauchy_erasure_encoder_tb;
	import cee_pkg::*;

	// Cycles to wait after the last expected result before a register write:
	// a symbol that closes nothing may still be working through sixteen rows.
	localparam int SettleCycles = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_NUM_INFO;
	logic [CfgW-1:0] cfg_data = '0;

	int failures, pending, symbols_seen, parity_seen;
	int send_stall_pct = 19;
	int recv_stall_pct = 71;
	int sent_total = 0;
	int random_sent = 0;
	int columns_sent = 0;
	int cur_info = 1;

	cee_info_if   info ();
	cee_parity_if parity ();

	cauchy_erasure_encoder dut (
		.clk(clk), .arst_n(arst_n), .info(info), .parity(parity),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cauchy_erasure_encoder_checker checker_i (
		.clk(clk), .arst_n(arst_n), .info(info), .parity(parity),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .pending(pending),
		.symbols_seen(symbols_seen), .parity_seen(parity_seen)
	);

	always #5 clk = ~clk;

	initial begin
		info.valid = 1'b0;
		info.info_symbol = '0;
		info.info_index = '0;
		info.word_last = 1'b0;
		parity.ready = 1'b0;
	end

	// The parity sink stalls at the rate of the current idling phase.
	always @(negedge clk)
		parity.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Idling phases follow the number of symbols sent so far.
	always @(negedge clk) begin
		if (sent_total < 35) begin
			send_stall_pct <= 19;
			recv_stall_pct <= 71;
		end else if (sent_total < 75) begin
			send_stall_pct <= 71;
			recv_stall_pct <= 19;
		end else begin
			send_stall_pct <= 0;
			recv_stall_pct <= 0;
		end
	end

	// Presents one symbol and holds it until the transfer. Valid stays high
	// into the next symbol unless the sender decides to idle; anything else
	// that waits drops it first.
	task automatic send_symbol(logic [15:0] sym, logic [7:0] idx, logic wl);
		while ($urandom_range(99) < send_stall_pct) begin
			info.valid <= 1'b0;
			@(negedge clk);
		end
		info.valid <= 1'b1;
		info.info_symbol <= sym;
		info.info_index <= idx;
		info.word_last <= wl;
		do @(posedge clk); while (!info.ready);
		sent_total++;
		@(negedge clk);
	endtask

	// Register writes only happen once the encoder has gone quiet.
	task automatic write_reg(cfg_reg_t which, int value);
		info.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= CfgW'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (which == REG_NUM_INFO) cur_info = value;
	endtask

	task automatic set_code(int n_info, int n_red);
		write_reg(REG_NUM_INFO, n_info);
		write_reg(REG_NUM_REDUNDANCY, n_red);
	endtask

	// One column: the lower indices in shuffled order, some of them dropped,
	// with the closing index last. A wide block only gets a sparse sample of
	// its lower indices. Now and then a stray index beyond the block is mixed
	// in; the encoder must ignore it.
	task automatic send_column(int n);
		int order[$];
		int tmp, j, final_pos;
		logic is_final;
		for (int i = 0; i < n - 1; i++)
			if (n <= 16 || $urandom_range(31) == 0) order.push_back(i);
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (order.size() > 1 && $urandom_range(9) == 0) void'(order.pop_front());
		order.push_back(n - 1);
		is_final = 1'($urandom_range(1));
		final_pos = $urandom_range(order.size() - 1);
		foreach (order[k]) begin
			if (n < 256 && $urandom_range(9) == 0) begin
				send_symbol(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255, n)), 1'b1);
				random_sent++;
			end
			send_symbol(16'($urandom_range(16'hFFFF)), 8'(order[k]),
				is_final && k == final_pos);
			random_sent++;
		end
		columns_sent++;
	endtask

	initial begin
		int codes[8][2];
		int limit;
		codes = '{'{2, 3}, '{5, 16}, '{1, 16}, '{7, 2}, '{3, 9}, '{256, 2},
			'{4, 31}, '{300, 1}};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Reset values: one info packet, one row, so index zero
		// closes a column and comes straight back as the XOR row; 255 is ignored.
		send_symbol(16'h0000, 8'd0, 1'b0);
		send_symbol(16'hFFFF, 8'd0, 1'b1);
		send_symbol(16'hA5A5, 8'd255, 1'b1);

		// Sixteen rows over four packets, with field extremes, then an index
		// beyond the block, index two and the closing index.
		set_code(4, 16);
		send_symbol(16'hFFFF, 8'd0, 1'b0);
		send_symbol(16'h0001, 8'd1, 1'b1);
		send_symbol(16'h1234, 8'd200, 1'b0);
		send_symbol(16'h8000, 8'd2, 1'b0);
		send_symbol(16'h5555, 8'd3, 1'b0);
		// Out-of-order column: the closing packet is not last to be needed.
		send_symbol(16'h00FF, 8'd2, 1'b0);
		send_symbol(16'hAAAA, 8'd3, 1'b0);
		send_symbol(16'h0F0F, 8'd0, 1'b1);
		send_symbol(16'hF00F, 8'd3, 1'b0);

		// No redundancy rows: columns close silently.
		set_code(3, 0);
		send_symbol(16'h7777, 8'd0, 1'b1);
		send_symbol(16'h8888, 8'd2, 1'b0);
		send_symbol(16'h9999, 8'd1, 1'b0);

		// No info packets at all: everything is ignored.
		set_code(0, 5);
		send_symbol(16'hFFFF, 8'd0, 1'b1);
		send_symbol(16'h0000, 8'd255, 1'b0);

		// Random part: whole columns under a series of codes; the widest
		// blocks, capped at 256, get only a single column each.
		foreach (codes[c]) begin
			set_code(codes[c][0], codes[c][1]);
			limit = random_sent + 8;
			do begin
				send_column(cur_info > 256 ? 256 : cur_info);
			end while (random_sent < limit && cur_info < 256);
		end
		set_code(1, 16);
		while (random_sent < 95) send_column(1);
		info.valid <= 1'b0;

		limit = 0;
		while (pending != 0 && limit < 200000) begin
			@(negedge clk);
			limit++;
		end
		repeat (SettleCycles) @(negedge clk);

		$display("Summary: %0d info symbols sent in %0d random columns plus directed cases,",
			symbols_seen, columns_sent);
		$display("         %0d parity symbols checked across twelve register settings.",
			parity_seen);
		if (failures == 0 && pending == 0)
			$display("cauchy_erasure_encoder verification clean");
		else
			$display("cauchy_erasure_encoder verification failed");
		$finish;
	end

	// Watchdog, well above the slowest correct run.
	initial begin
		#40ms;
		$display("cauchy_erasure_encoder verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/cee_pkg.sv
hdl/cee_if.sv
hdl/cauchy_erasure_encoder.sv
hdl/cee_checker.sv
test/cauchy_erasure_encoder_checker.sv
test/cauchy_erasure_encoder_tb.sv
